// ----- rtl/odrm_pkg.sv -----
// ----------------------------------------------------------------------------
// odrm_pkg
// Shared types, constants and tables for the ordered dither pixel core.
// ----------------------------------------------------------------------------
package odrm_pkg;

    localparam int FRAME_SIZE  = 240;
    localparam int MASK_CENTER = 120;

    localparam logic [9:0] GAIN_MIN   = 10'd102;
    localparam logic [9:0] GAIN_MAX   = 10'd768;
    localparam logic [9:0] GAIN_RESET = 10'd358;
    localparam logic [2:0] BSIZE_MIN   = 3'd1;
    localparam logic [2:0] BSIZE_MAX   = 3'd6;
    localparam logic [2:0] BSIZE_RESET = 3'd1;
    localparam logic [6:0] RADIUS_MIN   = 7'd48;
    localparam logic [6:0] RADIUS_MAX   = 7'd119;
    localparam logic [6:0] RADIUS_RESET = 7'd115;

    // full coverage level of the adjusted density
    localparam logic [6:0] DENSITY_FULL = 7'd64;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_CONTRAST_GAIN = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd1;
    localparam logic [1:0] CFG_MASK_RADIUS   = 2'd2;

    // reciprocals for the snap quotients (exact for 8-bit values)
    localparam logic [7:0] RECIP_3 = 8'd171;
    localparam logic [7:0] RECIP_5 = 8'd205;

    // 8x8 bayer thresholds, indexed by {row[2:0], col[2:0]}
    localparam logic [5:0] BAYER_TAB [0:63] = '{
        6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
        6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
        6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };

    // effective (clamped) configuration seen by the datapath
    typedef struct packed {
        logic [9:0] gain;
        logic [2:0] bsize;
        logic [6:0] radius;
    } cfg_t;

endpackage

// ----- rtl/odrm_snap.sv -----
// ----------------------------------------------------------------------------
// odrm_snap
// Snaps the pixel coordinates to the block grid and looks up the bayer
// threshold of the snapped point.
// ----------------------------------------------------------------------------
module odrm_snap (
    input  logic              clk,
    input  logic              en,
    input  odrm_pkg::cfg_t    cfg,
    input  logic [7:0]        pixel_x,
    input  logic [7:0]        pixel_y,
    output logic [7:0]        block_x,
    output logic [7:0]        block_y,
    output logic [5:0]        threshold
);

    logic [7:0]  qx_next;
    logic [7:0]  qy_next;
    logic [7:0]  qx_reg;
    logic [7:0]  qy_reg;
    logic [7:0]  bx_next;
    logic [7:0]  by_next;
    logic [7:0]  bx_reg;
    logic [7:0]  by_reg;
    logic [7:0]  bx3_reg;
    logic [7:0]  by3_reg;
    logic [5:0]  thr_reg;
    logic [10:0] mx;
    logic [10:0] my;

    function automatic logic [7:0] snap_quot(input logic [7:0] v, input logic [2:0] bs);
        logic [15:0] p3;
        logic [15:0] p5;
        logic [7:0]  q;
        p3 = 16'(v) * 16'(odrm_pkg::RECIP_3);
        p5 = 16'(v) * 16'(odrm_pkg::RECIP_5);
        case (bs)
            3'd2:    q = v >> 1;
            3'd3:    q = {1'b0, p3[15:9]};
            3'd4:    q = v >> 2;
            3'd5:    q = {2'b00, p5[15:10]};
            3'd6:    q = {2'b00, p3[15:10]};
            default: q = v;
        endcase
        return q;
    endfunction

    // stage 1: quotient by the block size
    always_comb
    begin
        qx_next = snap_quot(pixel_x, cfg.bsize);
        qy_next = snap_quot(pixel_y, cfg.bsize);
    end

    // stage 2: back to pixel units
    always_comb
    begin
        mx      = 11'(qx_reg) * 11'(cfg.bsize);
        my      = 11'(qy_reg) * 11'(cfg.bsize);
        bx_next = mx[7:0];
        by_next = my[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
            bx3_reg <= bx_reg;
            by3_reg <= by_reg;
            // stage 3: threshold of the snapped point
            thr_reg <= odrm_pkg::BAYER_TAB[{by_reg[2:0], bx_reg[2:0]}];
        end
    end

    assign block_x   = bx3_reg;
    assign block_y   = by3_reg;
    assign threshold = thr_reg;

endmodule

// ----- rtl/odrm_mask.sv -----
// ----------------------------------------------------------------------------
// odrm_mask
// Frame bounds and round mask test, three register stages.
// ----------------------------------------------------------------------------
module odrm_mask (
    input  logic              clk,
    input  logic              en,
    input  odrm_pkg::cfg_t    cfg,
    input  logic [7:0]        pixel_x,
    input  logic [7:0]        pixel_y,
    output logic              in_view
);

    logic signed [8:0] dx_next;
    logic signed [8:0] dy_next;
    logic        [7:0] ax_reg;
    logic        [7:0] ay_reg;
    logic              frame1_reg;
    logic              frame2_reg;
    logic       [15:0] sx_reg;
    logic       [15:0] sy_reg;
    logic       [13:0] r2_reg;
    logic       [16:0] dist_next;
    logic              view_reg;
    logic              frame_next;
    logic       [13:0] r2_full;

    // stage 1: offsets from the mask center as magnitudes
    always_comb
    begin
        dx_next    = $signed({1'b0, pixel_x}) - 9'sd120;
        dy_next    = $signed({1'b0, pixel_y}) - 9'sd120;
        frame_next = ({1'b0, pixel_x} < 9'(odrm_pkg::FRAME_SIZE)) &&
                     ({1'b0, pixel_y} < 9'(odrm_pkg::FRAME_SIZE));
        r2_full    = 14'(cfg.radius) * 14'(cfg.radius);
    end

    // stage 3 sum
    assign dist_next = 17'(sx_reg) + 17'(sy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= dx_next[8] ? 8'(-dx_next) : dx_next[7:0];
            ay_reg     <= dy_next[8] ? 8'(-dy_next) : dy_next[7:0];
            frame1_reg <= frame_next;
            // stage 2: squares
            sx_reg     <= 16'(ax_reg) * 16'(ax_reg);
            sy_reg     <= 16'(ay_reg) * 16'(ay_reg);
            r2_reg     <= r2_full;
            frame2_reg <= frame1_reg;
            // stage 3: compare against the radius
            view_reg   <= frame2_reg && (dist_next <= 17'(r2_reg));
        end
    end

    assign in_view = view_reg;

endmodule

// ----- rtl/odrm_contrast.sv -----
// ----------------------------------------------------------------------------
// odrm_contrast
// Contrast gain about 32 in Q8, floor and clamp to 0..64.
// ----------------------------------------------------------------------------
module odrm_contrast (
    input  logic              clk,
    input  logic              en,
    input  odrm_pkg::cfg_t    cfg,
    input  logic signed [8:0] density,
    output logic [6:0]        adj_density
);

    logic signed [9:0]  dm_next;
    logic signed [9:0]  dm_reg;
    logic signed [20:0] prod_reg;
    logic signed [20:0] v_next;
    logic        [12:0] q_next;
    logic        [6:0]  adj_next;
    logic        [6:0]  adj_reg;

    // stage 1: remove the pivot
    assign dm_next = 10'(density) - 10'sd32;

    // stage 3: re-add the pivot, floor and clamp
    always_comb
    begin
        v_next = prod_reg + 21'sd8192;
        q_next = v_next[20:8];
        if (v_next[20])
        begin
            adj_next = 7'd0;
        end
        else if (q_next > 13'(odrm_pkg::DENSITY_FULL))
        begin
            adj_next = odrm_pkg::DENSITY_FULL;
        end
        else
        begin
            adj_next = q_next[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg   <= dm_next;
            // stage 2: gain multiply
            prod_reg <= 21'(dm_reg) * $signed({11'd0, cfg.gain});
            adj_reg  <= adj_next;
        end
    end

    assign adj_density = adj_reg;

endmodule

// ----- rtl/ordered_dither_round_mask_pixel_core.sv -----
// ----------------------------------------------------------------------------
// ordered_dither_round_mask_pixel_core
// Ordered dither decision per pixel with a round display mask.
// ----------------------------------------------------------------------------
// One pixel per clock enters and one result per clock leaves while the
// output is not stalled; each pixel passes three compute stages and the
// output register. The whole pipeline holds while the output transfer is
// stalled. Configuration registers are plain writes and should change only
// while the pipeline is empty; out-of-range values are clamped before use.
module ordered_dither_round_mask_pixel_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_x[7:0], pixel_y[15:8], density[24:16], pixel_color[32:25], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lit[0], in_view[1], block_x[9:2], block_y[17:10], out_color[25:18], zero pad
    output logic [31:0] m_axis_tdata
);

    logic [9:0]  gain_reg;
    logic [2:0]  bsize_reg;
    logic [6:0]  radius_reg;
    odrm_pkg::cfg_t cfg;

    logic        adv;
    logic [2:0]  valid_reg;
    logic        out_valid_reg;
    logic [7:0]  color1_reg;
    logic [7:0]  color2_reg;
    logic [7:0]  color3_reg;

    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [8:0]  density;
    logic [7:0]  pixel_color;

    logic [7:0]  block_x;
    logic [7:0]  block_y;
    logic [5:0]  threshold;
    logic        in_view;
    logic [6:0]  adj_density;
    logic        lit_next;

    logic        lit_reg;
    logic        in_view_reg;
    logic [7:0]  block_x_reg;
    logic [7:0]  block_y_reg;
    logic [7:0]  color_reg;

    assign pixel_x     = s_axis_tdata[7:0];
    assign pixel_y     = s_axis_tdata[15:8];
    assign density     = s_axis_tdata[24:16];
    assign pixel_color = s_axis_tdata[32:25];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= odrm_pkg::GAIN_RESET;
            bsize_reg  <= odrm_pkg::BSIZE_RESET;
            radius_reg <= odrm_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                odrm_pkg::CFG_CONTRAST_GAIN: gain_reg   <= cfg_wdata;
                odrm_pkg::CFG_BLOCK_SIZE:    bsize_reg  <= cfg_wdata[2:0];
                odrm_pkg::CFG_MASK_RADIUS:   radius_reg <= cfg_wdata[6:0];
                default:                     ;
            endcase
        end
    end

    // clamp to the legal ranges
    always_comb
    begin
        cfg.gain   = (gain_reg < odrm_pkg::GAIN_MIN) ? odrm_pkg::GAIN_MIN :
                     (gain_reg > odrm_pkg::GAIN_MAX) ? odrm_pkg::GAIN_MAX : gain_reg;
        cfg.bsize  = (bsize_reg < odrm_pkg::BSIZE_MIN) ? odrm_pkg::BSIZE_MIN :
                     (bsize_reg > odrm_pkg::BSIZE_MAX) ? odrm_pkg::BSIZE_MAX : bsize_reg;
        cfg.radius = (radius_reg < odrm_pkg::RADIUS_MIN) ? odrm_pkg::RADIUS_MIN :
                     (radius_reg > odrm_pkg::RADIUS_MAX) ? odrm_pkg::RADIUS_MAX : radius_reg;
    end

    // whole pipe moves when the output register is free or being taken
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[1:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[2];
        end
    end

    odrm_snap u_snap (
        .clk       (clk),
        .en        (adv),
        .cfg       (cfg),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .block_x   (block_x),
        .block_y   (block_y),
        .threshold (threshold)
    );

    odrm_mask u_mask (
        .clk     (clk),
        .en      (adv),
        .cfg     (cfg),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .in_view (in_view)
    );

    odrm_contrast u_contrast (
        .clk         (clk),
        .en          (adv),
        .cfg         (cfg),
        .density     (density),
        .adj_density (adj_density)
    );

    // in view, full coverage always lights; otherwise beat the threshold (zero never does)
    assign lit_next = in_view && ((adj_density >= odrm_pkg::DENSITY_FULL) ||
                                  (adj_density > 7'(threshold)));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            color1_reg  <= pixel_color;
            color2_reg  <= color1_reg;
            color3_reg  <= color2_reg;
            lit_reg     <= lit_next;
            in_view_reg <= in_view;
            block_x_reg <= block_x;
            block_y_reg <= block_y;
            color_reg   <= color3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, color_reg, block_y_reg, block_x_reg, in_view_reg, lit_reg};

endmodule

// ----- tb/tb_ordered_dither_round_mask_pixel_core.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_dither_round_mask_pixel_core
// Streams pixels through the ordered dither core under several register
// settings and checks every output transfer against an in-bench model of the
// gain, block snap, bayer threshold and round mask decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_dither_round_mask_pixel_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 110;
    localparam int RANDOM_PHASES = 10;

    // bayer thresholds, row-major by {row[2:0], col[2:0]}
    localparam logic [5:0] DITHER_THRESH [0:63] = '{
        6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
        6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
        6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };

    typedef struct packed {
        logic [7:0] color;
        logic [8:0] density;
        logic [7:0] y;
        logic [7:0] x;
    } pixel_t;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] block_y;
        logic [7:0] block_x;
        logic       in_view;
        logic       lit;
    } dither_result_t;

    class dither_scoreboard;
        logic [9:0] gain_reg;
        logic [2:0] bsize_reg;
        logic [6:0] radius_reg;
        dither_result_t expected_q[$];
        pixel_t pixel_q[$];
        int errors;
        int n_pixels;
        int n_lit;
        int n_view;

        function new();
            gain_reg   = odrm_pkg::GAIN_RESET;
            bsize_reg  = odrm_pkg::BSIZE_RESET;
            radius_reg = odrm_pkg::RADIUS_RESET;
            errors = 0;
            n_pixels = 0;
            n_lit = 0;
            n_view = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [9:0] val);
            case (idx)
                odrm_pkg::CFG_CONTRAST_GAIN: gain_reg   = val;
                odrm_pkg::CFG_BLOCK_SIZE:    bsize_reg  = val[2:0];
                odrm_pkg::CFG_MASK_RADIUS:   radius_reg = val[6:0];
                default: ;
            endcase
        endfunction

        function int eff_radius();
            if (radius_reg < odrm_pkg::RADIUS_MIN)
                return odrm_pkg::RADIUS_MIN;
            if (radius_reg > odrm_pkg::RADIUS_MAX)
                return odrm_pkg::RADIUS_MAX;
            return radius_reg;
        endfunction

        function dither_result_t predict(pixel_t p);
            int g, bs, r, bx, by, dx, dy, d, v, a;
            logic on;
            dither_result_t e;
            g = (gain_reg < odrm_pkg::GAIN_MIN) ? odrm_pkg::GAIN_MIN :
                ((gain_reg > odrm_pkg::GAIN_MAX) ? odrm_pkg::GAIN_MAX : gain_reg);
            bs = (bsize_reg < odrm_pkg::BSIZE_MIN) ? odrm_pkg::BSIZE_MIN :
                 ((bsize_reg > odrm_pkg::BSIZE_MAX) ? odrm_pkg::BSIZE_MAX : bsize_reg);
            r = eff_radius();
            bx = (int'(p.x) / bs) * bs;
            by = (int'(p.y) / bs) * bs;
            dx = int'(p.x) - odrm_pkg::MASK_CENTER;
            dy = int'(p.y) - odrm_pkg::MASK_CENTER;
            e.in_view = (p.x < odrm_pkg::FRAME_SIZE) && (p.y < odrm_pkg::FRAME_SIZE) &&
                        (dx * dx + dy * dy <= r * r);
            d = $signed(p.density);
            v = (d - 32) * g + 32 * 256;
            a = (v < 0) ? 0 : (v >>> 8);
            if (a > odrm_pkg::DENSITY_FULL)
                a = odrm_pkg::DENSITY_FULL;
            if (a == 0)
                on = 1'b0;
            else if (a >= odrm_pkg::DENSITY_FULL)
                on = 1'b1;
            else
                on = a > DITHER_THRESH[(by % 8) * 8 + (bx % 8)];
            e.lit = e.in_view && on;
            e.block_x = bx[7:0];
            e.block_y = by[7:0];
            e.color = p.color;
            return e;
        endfunction

        function void note_pixel(pixel_t p);
            dither_result_t e;
            e = predict(p);
            expected_q.push_back(e);
            pixel_q.push_back(p);
            n_pixels++;
            if (e.lit)
                n_lit++;
            if (e.in_view)
                n_view++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [31:0] word);
            dither_result_t e, got;
            pixel_t p;
            string ctx;
            got = word[25:0];
            if (expected_q.size() == 0)
            begin
                report($sformatf("output transfer 0x%08h with no pixel pending", word));
                return;
            end
            e = expected_q.pop_front();
            p = pixel_q.pop_front();
            ctx = $sformatf("x=%0d y=%0d d=%0d", p.x, p.y, $signed(p.density));
            if (got.lit !== e.lit)
                report($sformatf("%s lit %b want %b", ctx, got.lit, e.lit));
            if (got.in_view !== e.in_view)
                report($sformatf("%s in_view %b want %b", ctx, got.in_view, e.in_view));
            if (got.block_x !== e.block_x)
                report($sformatf("%s block_x %0d want %0d", ctx, got.block_x, e.block_x));
            if (got.block_y !== e.block_y)
                report($sformatf("%s block_y %0d want %0d", ctx, got.block_y, e.block_y));
            if (got.color !== e.color)
                report($sformatf("%s out_color %0d want %0d", ctx, got.color, e.color));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    dither_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int stall_left = 0;
    int settings_used = 0;

    ordered_dither_round_mask_pixel_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending());
            $display("tb_ordered_dither_round_mask_pixel_core failed");
            $finish;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // receiver backpressure: always ready, random stalls, or stall runs
    always @(negedge clk)
    begin
        if (cycle_count % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left = $urandom_range(0, 7);
                        m_axis_tready <= 1'b0;
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
            endcase
        end
    end

    function automatic pixel_t mk(int x, int y, int d, int c);
        pixel_t p;
        p.x = x[7:0];
        p.y = y[7:0];
        p.density = d[8:0];
        p.color = c[7:0];
        return p;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_pixel(pixel_t p);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, p.color, p.density, p.y, p.x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic push_pixel(pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        send_pixel(p);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(int gain, int bsize, int radius);
        wait_idle();
        write_reg(odrm_pkg::CFG_CONTRAST_GAIN, gain[9:0]);
        write_reg(odrm_pkg::CFG_BLOCK_SIZE, {7'd0, bsize[2:0]});
        write_reg(odrm_pkg::CFG_MASK_RADIUS, {3'd0, radius[6:0]});
        settings_used++;
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        int r, pick;
        p.x = 8'($urandom_range(0, 255));
        p.y = 8'($urandom_range(0, 255));
        p.color = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            p.density = 9'($urandom_range(0, 88) - 8);
        else if (pick == 4)
            p.density = ($urandom_range(0, 1) != 0) ? 9'h100 : 9'h0ff;
        else
            p.density = 9'($urandom_range(0, 511));
        // put some pixels right on or just past the mask edge
        if ($urandom_range(0, 6) == 0)
        begin
            r = sb.eff_radius() + $urandom_range(0, 1);
            if ($urandom_range(0, 1) != 0)
            begin
                p.x = ($urandom_range(0, 1) != 0) ? 8'(odrm_pkg::MASK_CENTER + r)
                                                  : 8'(odrm_pkg::MASK_CENTER - r);
                p.y = 8'(odrm_pkg::MASK_CENTER);
            end
            else
            begin
                p.x = 8'(odrm_pkg::MASK_CENTER);
                p.y = ($urandom_range(0, 1) != 0) ? 8'(odrm_pkg::MASK_CENTER + r)
                                                  : 8'(odrm_pkg::MASK_CENTER - r);
            end
        end
        return p;
    endfunction

    function automatic int random_gain();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 101);
            1: return odrm_pkg::GAIN_MIN;
            2: return odrm_pkg::GAIN_MAX;
            3: return $urandom_range(769, 1023);
            default: return $urandom_range(102, 768);
        endcase
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: field extremes, mask edge at radius 115, frame bounds
        push_pixel(mk(0, 0, -256, 0));
        push_pixel(mk(255, 255, 255, 255));
        push_pixel(mk(120, 120, 64, 1));
        push_pixel(mk(120, 120, 0, 2));
        push_pixel(mk(120, 121, 32, 3));
        push_pixel(mk(121, 120, 33, 4));
        push_pixel(mk(120, 5, 100, 5));
        push_pixel(mk(120, 4, 100, 6));
        push_pixel(mk(235, 120, 200, 7));
        push_pixel(mk(236, 120, 200, 8));
        push_pixel(mk(240, 120, 255, 9));
        push_pixel(mk(120, 240, 255, 10));
        push_pixel(mk(100, 100, -1, 11));
        push_pixel(mk(7, 7, 40, 12));

        // below-range register values clamp to the low limits
        apply_setting(0, 0, 0);
        push_pixel(mk(120, 72, 64, 13));
        push_pixel(mk(120, 71, 64, 14));
        push_pixel(mk(168, 120, 48, 15));

        // above-range register values clamp to the high limits
        apply_setting(1023, 7, 127);
        push_pixel(mk(239, 120, 40, 16));
        push_pixel(mk(1, 120, 40, 17));
        push_pixel(mk(0, 120, 255, 18));
        push_pixel(mk(255, 255, 33, 19));
        push_pixel(mk(17, 23, 33, 20));

        apply_setting(odrm_pkg::GAIN_MIN, 3, odrm_pkg::RADIUS_MAX);
        push_pixel(mk(200, 131, 50, 21));
        apply_setting(odrm_pkg::GAIN_MAX, 5, odrm_pkg::RADIUS_MIN);
        push_pixel(mk(129, 154, 31, 22));
        apply_setting(256, 2, 100);
        push_pixel(mk(83, 77, 45, 23));
        apply_setting(300, 4, 90);
        push_pixel(mk(98, 141, 20, 24));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_setting(random_gain(), $urandom_range(0, 7),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(48, 119));
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_pixel(random_pixel());
        end

        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("checked %0d pixels across %0d register settings", sb.n_pixels,
                 settings_used + 1);
        $display("%0d pixels in view, %0d lit, %0d mismatches", sb.n_view, sb.n_lit,
                 sb.errors);
        if (sb.errors == 0)
            $display("tb_ordered_dither_round_mask_pixel_core passed");
        else
            $display("tb_ordered_dither_round_mask_pixel_core failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/odrm_pkg.sv
rtl/odrm_snap.sv
rtl/odrm_mask.sv
rtl/odrm_contrast.sv
rtl/ordered_dither_round_mask_pixel_core.sv
tb/tb_ordered_dither_round_mask_pixel_core.sv
